// ===== design/quaternion_arithmetic_unit_assert.svh =====
// Assertion macros for the quaternion arithmetic unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quaternion unit check failed");

// Consequent must hold in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quaternion unit check failed");

`endif

// ===== design/qau_pkg.sv =====
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; every other design file but the assertion macro header depends on it.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

	// Default component format: Q2.14 in 16 bits.
	localparam int COMP_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// Opcode field width and opcodes.
	localparam int OP_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 3'd0,
		OP_MUL   = 3'd1,
		OP_DIV   = 3'd2,
		OP_SCALE = 3'd3,
		OP_DOT   = 3'd4,
		OP_CONJ  = 3'd5
	} op_t;

	// Component lanes in x, y, z, w order.
	localparam int LANES = 4;

endpackage

`default_nettype wire

// ===== design/qau_if.sv =====
// Valid/ready channel interfaces for the quaternion arithmetic unit.
// Depends on qau_pkg for the opcode width and the default component width.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: opcode, quaternions a and b, and a scalar.
interface qau_req_if #(
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
);
	logic                               valid;
	logic                               ready;
	logic        [qau_pkg::OP_W-1:0]    op;
	logic signed [COMP_WIDTH-1:0]       a_x;
	logic signed [COMP_WIDTH-1:0]       a_y;
	logic signed [COMP_WIDTH-1:0]       a_z;
	logic signed [COMP_WIDTH-1:0]       a_w;
	logic signed [COMP_WIDTH-1:0]       b_x;
	logic signed [COMP_WIDTH-1:0]       b_y;
	logic signed [COMP_WIDTH-1:0]       b_z;
	logic signed [COMP_WIDTH-1:0]       b_w;
	logic signed [COMP_WIDTH-1:0]       scale_factor;

	modport source (
		output valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		input  ready
	);

	modport sink (
		input  valid, op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor,
		output ready
	);
endinterface

// Response channel: result quaternion and saturation flag.
interface qau_rsp_if #(
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] res_x;
	logic signed [COMP_WIDTH-1:0] res_y;
	logic signed [COMP_WIDTH-1:0] res_z;
	logic signed [COMP_WIDTH-1:0] res_w;
	logic                         saturated;

	modport source (
		output valid, res_x, res_y, res_z, res_w, saturated,
		input  ready
	);

	modport sink (
		input  valid, res_x, res_y, res_z, res_w, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: an accepted item passes the input register and then the result register before rsp.
// Throughput one item per cycle while rsp is ready; input register feeds the datapath, result register drives rsp.
// The request side keeps accepting while a result waits, as long as the input stage is empty.
// arst_n low clears both stage valid flags asynchronously; payload registers are not reset.
// Depends on qau_pkg, qau_if, qau_datapath and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_arithmetic_unit_assert.svh"

module quaternion_arithmetic_unit #(
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qau_req_if.sink   req,
	qau_rsp_if.source rsp
);
	import qau_pkg::*;

	logic                        v_s1;
	logic        [OP_W-1:0]      op_s1;
	logic signed [COMP_WIDTH-1:0] a_s1 [LANES];
	logic signed [COMP_WIDTH-1:0] b_s1 [LANES];
	logic signed [COMP_WIDTH-1:0] s_s1;

	logic                        v_s2;
	logic signed [COMP_WIDTH-1:0] res_s2 [LANES];
	logic                        sat_s2;

	logic signed [COMP_WIDTH-1:0] res_c [LANES];
	logic                        sat_c;
	logic                        adv;

	// Stage 2 can take a new item when empty or when its item leaves.
	assign adv       = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.op;
			a_s1[0] <= req.a_x;
			a_s1[1] <= req.a_y;
			a_s1[2] <= req.a_z;
			a_s1[3] <= req.a_w;
			b_s1[0] <= req.b_x;
			b_s1[1] <= req.b_y;
			b_s1[2] <= req.b_z;
			b_s1[3] <= req.b_w;
			s_s1    <= req.scale_factor;
		end
	end

	// Arithmetic between the two registers.
	qau_datapath #(
		.COMP_WIDTH(COMP_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.op       (op_s1),
		.a        (a_s1),
		.b        (b_s1),
		.s        (s_s1),
		.res      (res_c),
		.saturated(sat_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_s2 <= res_c;
			sat_s2 <= sat_c;
		end
	end

	assign rsp.valid     = v_s2;
	assign rsp.res_x     = res_s2[0];
	assign rsp.res_y     = res_s2[1];
	assign rsp.res_z     = res_s2[2];
	assign rsp.res_w     = res_s2[3];
	assign rsp.saturated = sat_s2;

	// An item leaving the input stage must show up as a valid result.
	`QAU_ASSERT_NEXT(a_stage_moves, v_s1 && adv, rsp.valid)
	// A dot product leaves the vector part of the result at zero.
	`QAU_ASSERT_NEXT(a_dot_zero_vec, v_s1 && adv && op_s1 == OP_DOT,
		rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0)
	// The conjugate passes the real part through unchanged and unclipped.
	`QAU_ASSERT_NEXT(a_conj_real, v_s1 && adv && op_s1 == OP_CONJ,
		rsp.res_w == $past(a_s1[3]))
	// Unused opcodes give an all-zero result without saturation; the check covers x and w only.
	`QAU_ASSERT_NEXT(a_unused_zero,
		v_s1 && adv && op_s1 != OP_ADD && op_s1 != OP_MUL && op_s1 != OP_DIV &&
		op_s1 != OP_SCALE && op_s1 != OP_DOT && op_s1 != OP_CONJ,
		rsp.res_w == '0 && rsp.res_x == '0 && !rsp.saturated)
endmodule

`default_nettype wire

// ===== design/qau_round_sat.sv =====
// Rounding and saturation of one full-precision result component.
// Depends on qau_pkg for the default component format.
`timescale 1ns / 1ps
`default_nettype none

module qau_round_sat #(
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  wire logic signed [2*COMP_WIDTH+1:0] val,
	input  wire logic                           rnd,
	output logic signed [COMP_WIDTH-1:0]        res,
	output logic                                sat
);
	localparam int SW = 2*COMP_WIDTH + 2;
	localparam logic signed [SW-1:0] RND_BIAS = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] CMAX     = (SW'(1) << (COMP_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] CMIN     = -CMAX - SW'(1);

	logic signed [SW-1:0] biased;
	logic signed [SW-1:0] shifted;

	// Round to nearest, ties toward plus infinity, for product terms only.
	always_comb begin
		biased  = val + RND_BIAS;
		shifted = rnd ? (biased >>> FRAC_BITS) : val;
	end

	// Clip to the component range and flag any clipping.
	always_comb begin
		if (shifted > CMAX) begin
			res = CMAX[COMP_WIDTH-1:0];
			sat = 1'b1;
		end else if (shifted < CMIN) begin
			res = CMIN[COMP_WIDTH-1:0];
			sat = 1'b1;
		end else begin
			res = shifted[COMP_WIDTH-1:0];
			sat = 1'b0;
		end
	end
endmodule

`default_nettype wire

// ===== design/qau_datapath.sv =====
// Combinational quaternion datapath: products, sums, opcode select, rounding, saturation.
// Depends on qau_pkg and qau_round_sat.
`timescale 1ns / 1ps
`default_nettype none

module qau_datapath #(
	parameter int COMP_WIDTH = qau_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
	input  wire logic        [qau_pkg::OP_W-1:0] op,
	input  wire logic signed [COMP_WIDTH-1:0]    a [qau_pkg::LANES],
	input  wire logic signed [COMP_WIDTH-1:0]    b [qau_pkg::LANES],
	input  wire logic signed [COMP_WIDTH-1:0]    s,
	output logic signed [COMP_WIDTH-1:0]         res [qau_pkg::LANES],
	output logic                                 saturated
);
	import qau_pkg::*;

	localparam int PW = 2*COMP_WIDTH;
	localparam int SW = 2*COMP_WIDTH + 2;

	logic signed [PW-1:0] ab [LANES][LANES];
	logic signed [PW-1:0] sa [LANES];
	logic signed [SW-1:0] g [LANES];
	logic signed [SW-1:0] ham [LANES];
	logic signed [SW-1:0] dot;
	logic signed [SW-1:0] val [LANES];
	logic                 rnd;
	logic                 sat [LANES];

	function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
		return SW'(p);
	endfunction

	// All cross products a_i * b_j and the scaled components s * a_i.
	for (genvar i = 0; i < LANES; i++) begin : g_prod
		for (genvar j = 0; j < LANES; j++) begin : g_col
			assign ab[i][j] = a[i] * b[j];
		end
		assign sa[i] = s * a[i];
	end

	// Hamilton product terms that involve the vector part of b; the divide
	// operation conjugates b, which flips the sign of exactly these terms.
	always_comb begin
		g[0] = ext(ab[3][0]) + ext(ab[1][2]) - ext(ab[2][1]);
		g[1] = ext(ab[3][1]) + ext(ab[2][0]) - ext(ab[0][2]);
		g[2] = ext(ab[3][2]) + ext(ab[0][1]) - ext(ab[1][0]);
		g[3] = -(ext(ab[0][0]) + ext(ab[1][1]) + ext(ab[2][2]));
		for (int i = 0; i < LANES; i++) begin
			ham[i] = ext(ab[i][3]) + ((op == OP_DIV) ? -g[i] : g[i]);
		end
		dot = ext(ab[0][0]) + ext(ab[1][1]) + ext(ab[2][2]) + ext(ab[3][3]);
	end

	// Select the full-precision result per component by opcode.
	always_comb begin
		rnd = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			val[i] = '0;
		end
		unique case (op)
			OP_ADD: begin
				for (int i = 0; i < LANES; i++) begin
					val[i] = SW'(a[i]) + SW'(b[i]);
				end
			end
			OP_MUL, OP_DIV: begin
				rnd = 1'b1;
				for (int i = 0; i < LANES; i++) begin
					val[i] = ham[i];
				end
			end
			OP_SCALE: begin
				rnd = 1'b1;
				for (int i = 0; i < LANES; i++) begin
					val[i] = ext(sa[i]);
				end
			end
			OP_DOT: begin
				rnd    = 1'b1;
				val[3] = dot;
			end
			OP_CONJ: begin
				for (int i = 0; i < LANES - 1; i++) begin
					val[i] = -SW'(a[i]);
				end
				val[3] = SW'(a[3]);
			end
			default: begin
				rnd = 1'b0;
			end
		endcase
	end

	// Rounding and saturation per component.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		qau_round_sat #(
			.COMP_WIDTH(COMP_WIDTH),
			.FRAC_BITS (FRAC_BITS)
		) u_round_sat (
			.val(val[i]),
			.rnd(rnd),
			.res(res[i]),
			.sat(sat[i])
		);
	end

	assign saturated = sat[0] | sat[1] | sat[2] | sat[3];
endmodule

`default_nettype wire
